// ----- rtl/sos_pkg.sv -----
// Shared types and constants for the sonar obstacle steering block.
// No dependencies; imported by sos_reading_dec and sonar_obstacle_steering.
package sos_pkg;

    localparam int THR_W   = 14;
    localparam int PLEN_W  = 8;
    localparam int DIST_W  = 19;   // four digits of -48..207, weighted 1000/100/10/1

    localparam logic [1:0] MOTOR_STOP = 2'd0;
    localparam logic [1:0] MOTOR_FWD  = 2'd1;
    localparam logic [1:0] MOTOR_REV  = 2'd2;

    localparam logic [1:0] STEER_STRAIGHT = 2'd0;
    localparam logic [1:0] STEER_LEFT     = 2'd1;
    localparam logic [1:0] STEER_RIGHT    = 2'd2;

    localparam logic [1:0] REG_CLOSE_THR = 2'd0;
    localparam logic [1:0] REG_NEAR_THR  = 2'd1;
    localparam logic [1:0] REG_PAUSE_LEN = 2'd2;

    localparam logic [THR_W-1:0]  CLOSE_THR_RST = 14'd20;
    localparam logic [THR_W-1:0]  NEAR_THR_RST  = 14'd50;
    localparam logic [PLEN_W-1:0] PAUSE_LEN_RST = 8'd10;

    typedef struct packed {
        logic close;
        logic near;
    } sos_flags_t;

endpackage

// ----- rtl/sos_reading_dec.sv -----
// Converts one four-byte ASCII sonar reading to a distance and compares it
// against the close and near thresholds. Depends on sos_pkg.
module sos_reading_dec
    import sos_pkg::*;
(
    input  logic [31:0]      digits,
    input  logic [THR_W-1:0] close_thr,
    input  logic [THR_W-1:0] near_thr,
    output sos_flags_t       flags
);

    logic signed [8:0]        d0, d1, d2, d3;
    logic signed [DIST_W-1:0] e0, e1, e2, e3;
    logic signed [DIST_W-1:0] dist_val;
    logic signed [DIST_W-1:0] close_s, near_s;

    // byte minus ASCII '0', no range check
    assign d0 = signed'({1'b0, digits[31:24]}) - 9'sd48;
    assign d1 = signed'({1'b0, digits[23:16]}) - 9'sd48;
    assign d2 = signed'({1'b0, digits[15:8]})  - 9'sd48;
    assign d3 = signed'({1'b0, digits[7:0]})   - 9'sd48;

    assign e0 = DIST_W'(d0);
    assign e1 = DIST_W'(d1);
    assign e2 = DIST_W'(d2);
    assign e3 = DIST_W'(d3);

    assign dist_val = e0 * 19'sd1000 + e1 * 19'sd100 + e2 * 19'sd10 + e3;

    assign close_s = signed'({{(DIST_W-THR_W){1'b0}}, close_thr});
    assign near_s  = signed'({{(DIST_W-THR_W){1'b0}}, near_thr});

    assign flags.close = dist_val < close_s;
    assign flags.near  = dist_val < near_s;

endmodule

// ----- rtl/sonar_obstacle_steering.sv -----
// Top level of the sonar obstacle steering block: stream ports, APB registers,
// flag register and steering state. Depends on sos_pkg and sos_reading_dec.
//
// One transfer in gives one transfer out. Readings are decoded and compared
// against the thresholds on the way into a flag register; the steering/pause
// state then updates from that register once the output register is empty or
// being drained, and that state is the result presented on m_axis_tdata.
// m_axis_tvalid is registered and rises with that update, and a new transfer is
// taken every cycle while the output is drained. The flag register lets one
// more transfer in while a result waits on m_axis_tready.
// Thresholds and pause length must be written only while the block is empty.
module sonar_obstacle_steering
    import sos_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,   // left_digits[31:0], center_digits[63:32], right_digits[95:64]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // motor_cmd[1:0], steer_cmd[3:2], paused[4], zeros
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [THR_W-1:0]  close_thr_reg;
    logic [THR_W-1:0]  near_thr_reg;
    logic [PLEN_W-1:0] pause_len_reg;

    sos_flags_t fl_l, fl_c, fl_r;
    sos_flags_t fl_l_reg, fl_c_reg, fl_r_reg;
    logic       s1_valid_reg;
    logic       out_valid_reg;
    logic       advance;
    logic       cfg_wr;

    logic [1:0]        motor_reg, motor_next;
    logic [1:0]        steer_reg, steer_next;
    logic [1:0]        prev_motor_reg, prev_motor_next;
    logic              pause_flag_reg, pause_flag_next;
    logic [PLEN_W-1:0] pause_cnt_reg, pause_cnt_next;
    logic [PLEN_W-1:0] cnt_dec;
    logic [1:0]        dec_motor, dec_steer;
    logic              l, c, r;

    sos_reading_dec u_dec_l (
        .digits(s_axis_tdata[31:0]), .close_thr(close_thr_reg),
        .near_thr(near_thr_reg), .flags(fl_l)
    );
    sos_reading_dec u_dec_c (
        .digits(s_axis_tdata[63:32]), .close_thr(close_thr_reg),
        .near_thr(near_thr_reg), .flags(fl_c)
    );
    sos_reading_dec u_dec_r (
        .digits(s_axis_tdata[95:64]), .close_thr(close_thr_reg),
        .near_thr(near_thr_reg), .flags(fl_r)
    );

    // handshake
    assign advance       = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, pause_flag_reg, steer_reg, motor_reg};

    // APB
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        case (paddr[3:2])
            REG_CLOSE_THR: prdata = {{(32-THR_W){1'b0}}, close_thr_reg};
            REG_NEAR_THR:  prdata = {{(32-THR_W){1'b0}}, near_thr_reg};
            REG_PAUSE_LEN: prdata = {{(32-PLEN_W){1'b0}}, pause_len_reg};
            default:       prdata = 32'd0;
        endcase
    end

    // steering decision
    assign l = fl_l_reg.near;
    assign c = fl_c_reg.near;
    assign r = fl_r_reg.near;

    always_comb
    begin
        if ((!l && !c && !r) || (l && !c && r))
        begin
            dec_motor = MOTOR_FWD;
            dec_steer = STEER_STRAIGHT;
        end
        else if ((r && !l) || (!l && c))
        begin
            dec_motor = MOTOR_FWD;
            dec_steer = STEER_LEFT;
        end
        else if (!r && l)
        begin
            dec_motor = MOTOR_FWD;
            dec_steer = STEER_RIGHT;
        end
        else
        begin
            dec_motor = MOTOR_REV;
            dec_steer = STEER_STRAIGHT;
        end
    end

    assign cnt_dec = pause_cnt_reg - 8'd1;

    always_comb
    begin
        prev_motor_next = pause_flag_reg ? prev_motor_reg : motor_reg;
        motor_next      = motor_reg;
        steer_next      = steer_reg;
        pause_flag_next = pause_flag_reg;
        pause_cnt_next  = pause_cnt_reg;
        if (fl_l_reg.close || fl_c_reg.close || fl_r_reg.close)
        begin
            // close obstacle: reverse at once, steering and pause untouched
            motor_next = MOTOR_REV;
        end
        else if ((dec_motor == MOTOR_REV && prev_motor_next == MOTOR_FWD) || pause_flag_reg)
        begin
            motor_next = MOTOR_STOP;
            steer_next = STEER_STRAIGHT;
            if (cnt_dec == '0)
            begin
                pause_flag_next = 1'b0;
                pause_cnt_next  = pause_len_reg;
            end
            else
            begin
                pause_flag_next = 1'b1;
                pause_cnt_next  = cnt_dec;
            end
        end
        else
        begin
            motor_next = dec_motor;
            steer_next = dec_steer;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            fl_l_reg <= fl_l;
            fl_c_reg <= fl_c;
            fl_r_reg <= fl_r;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            close_thr_reg  <= CLOSE_THR_RST;
            near_thr_reg   <= NEAR_THR_RST;
            pause_len_reg  <= PAUSE_LEN_RST;
            motor_reg      <= MOTOR_STOP;
            steer_reg      <= STEER_STRAIGHT;
            prev_motor_reg <= MOTOR_STOP;
            pause_flag_reg <= 1'b0;
            pause_cnt_reg  <= PAUSE_LEN_RST;
        end
        else
        begin
            if (cfg_wr)
            begin
                case (paddr[3:2])
                    REG_CLOSE_THR: close_thr_reg <= pwdata[THR_W-1:0];
                    REG_NEAR_THR:  near_thr_reg  <= pwdata[THR_W-1:0];
                    REG_PAUSE_LEN:
                    begin
                        pause_len_reg <= pwdata[PLEN_W-1:0];
                        if (!pause_flag_reg)
                            pause_cnt_reg <= pwdata[PLEN_W-1:0];
                    end
                    default: ;
                endcase
            end
            else if (advance)
            begin
                motor_reg      <= motor_next;
                steer_reg      <= steer_next;
                prev_motor_reg <= prev_motor_next;
                pause_flag_reg <= pause_flag_next;
                pause_cnt_reg  <= pause_cnt_next;
            end
        end
    end

`ifndef SYNTHESIS
    a_no_fwd_in_pause: assert property (@(posedge clk) disable iff (!rst_n)
        pause_flag_reg |-> motor_reg != MOTOR_FWD)
        else $error("forward drive while paused");

    a_pause_entry_stops: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pause_flag_reg) |-> motor_reg == MOTOR_STOP && steer_reg == STEER_STRAIGHT)
        else $error("pause entered without stop");

    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !advance && !cfg_wr |=> $stable(motor_reg) && $stable(steer_reg)
            && $stable(pause_flag_reg))
        else $error("steering state changed without a transfer");

    a_item_kept: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !advance |=> s1_valid_reg)
        else $error("pending item dropped");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("result not presented after update");
`endif

endmodule

// ----- test/sonar_obstacle_steering_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for sonar_obstacle_steering: streams sonar frames in, sets
// thresholds over APB and checks each drive result against a local predictor or, for typed directed rows, the table.
// Depends on sos_pkg and the sonar_obstacle_steering top level.
module sonar_obstacle_steering_tb;
    import sos_pkg::*;

    localparam int LIMIT_CYCLES  = 500000;
    localparam int SETTLE_CYCLES = 8;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic       paused;
        logic [1:0] steer;
        logic [1:0] motor;
    } drive_t;

    typedef struct {
        logic [31:0] left;
        logic [31:0] center;
        logic [31:0] right;
        bit          typed;
        logic [1:0]  motor;
        logic [1:0]  steer;
        logic        paused;
    } frame_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata = '0;     // left_digits[31:0], center_digits[63:32], right_digits[95:64]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;          // motor_cmd[1:0], steer_cmd[3:2], paused[4], zeros
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // predictor state and register copies
    logic [1:0]        mdl_motor;
    logic [1:0]        mdl_steer;
    logic [1:0]        mdl_prev;
    logic              mdl_pausing;
    logic [7:0]        mdl_count;
    logic [THR_W-1:0]  cfg_close;
    logic [THR_W-1:0]  cfg_near;
    logic [PLEN_W-1:0] cfg_plen;

    drive_t pending_drive[$];
    int     mismatches = 0;
    int     frames_sent = 0;
    int     results_seen = 0;
    int     paused_seen = 0;
    int     settings_run = 1;
    int     burst_left = 0;
    int     cycle_count = 0;
    logic [15:0] ready_tick = '0;
    logic [1:0]  ready_mode = '0;

    // directed frames, reset thresholds (close 20, near 50, pause 10)
    frame_row_t dir_rows [24] = '{
        '{"9999", "9999", "9999", 1'b1, MOTOR_FWD,  STEER_STRAIGHT, 1'b0},
        '{"0100", "0030", "9999", 1'b1, MOTOR_FWD,  STEER_LEFT,     1'b0},
        '{"0030", "9999", "9999", 1'b1, MOTOR_FWD,  STEER_RIGHT,    1'b0},
        '{"0030", "9999", "0030", 1'b1, MOTOR_FWD,  STEER_STRAIGHT, 1'b0},
        '{"9999", "9999", "0030", 1'b1, MOTOR_FWD,  STEER_LEFT,     1'b0},
        '{"0000", "9999", "9999", 1'b1, MOTOR_REV,  STEER_LEFT,     1'b0},
        '{"9999", "9999", "9999", 1'b1, MOTOR_FWD,  STEER_STRAIGHT, 1'b0},
        '{"0030", "0030", "0030", 1'b1, MOTOR_STOP, STEER_STRAIGHT, 1'b1},
        '{32'h0,  32'h0,  32'h0,  1'b1, MOTOR_REV,  STEER_STRAIGHT, 1'b1},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0,
          MOTOR_STOP, STEER_STRAIGHT, 1'b0},
        '{"0020", "0050", "9999", 1'b0, MOTOR_STOP, STEER_STRAIGHT, 1'b0},
        '{"9999", "9999", "9999", 1'b0, MOTOR_STOP, STEER_STRAIGHT, 1'b0},
        '{"9999", "9999", "9999", 1'b0, MOTOR_STOP, STEER_STRAIGHT, 1'b0},
        '{"9999", "9999", "9999", 1'b0, MOTOR_STOP, STEER_STRAIGHT, 1'b0},
        '{"9999", "9999", "9999", 1'b0, MOTOR_STOP, STEER_STRAIGHT, 1'b0},
        '{"9999", "9999", "9999", 1'b0, MOTOR_STOP, STEER_STRAIGHT, 1'b0},
        '{"9999", "9999", "9999", 1'b0, MOTOR_STOP, STEER_STRAIGHT, 1'b0},
        '{"9999", "9999", "9999", 1'b0, MOTOR_STOP, STEER_STRAIGHT, 1'b0},
        '{"0019", "9999", "9999", 1'b0, MOTOR_STOP, STEER_STRAIGHT, 1'b0},
        '{"9999", "0049", "9999", 1'b0, MOTOR_STOP, STEER_STRAIGHT, 1'b0},
        '{"9999", ":9?9", "9999", 1'b0, MOTOR_STOP, STEER_STRAIGHT, 1'b0},
        '{"9999", "9999", "/999", 1'b0, MOTOR_STOP, STEER_STRAIGHT, 1'b0},
        '{"0099", "0099", "0099", 1'b0, MOTOR_STOP, STEER_STRAIGHT, 1'b0},
        '{"0049", "0049", "0049", 1'b0, MOTOR_STOP, STEER_STRAIGHT, 1'b0}
    };

    // threshold settings walked after the reset setting
    int ph_close [7] = '{100, 0,    500,  9999, 30,   0, 20};
    int ph_near  [7] = '{400, 9999, 9999, 9999, 2000, 0, 50};
    int ph_plen  [7] = '{3,   1,    255,  7,    0,    1, 10};
    int ph_items [7] = '{120, 80,   120,  50,   260,  40, 60};

    sonar_obstacle_steering dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int reading_dist(logic [31:0] w);
        int         d;
        logic [7:0] b;
        d = 0;
        for (int k = 0; k < 4; k++)
        begin
            b = w[31 - 8*k -: 8];
            d = d * 10 + int'(b) - 48;
        end
        return d;
    endfunction

    task automatic compute_drive(input logic [95:0] frame, output drive_t res);
        int dl, dc, dr, ct, nt;
        bit l, c, r;
        dl = reading_dist(frame[31:0]);
        dc = reading_dist(frame[63:32]);
        dr = reading_dist(frame[95:64]);
        ct = int'(cfg_close);
        nt = int'(cfg_near);
        if (!mdl_pausing)
            mdl_prev = mdl_motor;
        if (dl < ct || dc < ct || dr < ct)
            mdl_motor = MOTOR_REV;      // steering and pause untouched
        else
        begin
            l = dl < nt;
            c = dc < nt;
            r = dr < nt;
            if ((!l && !c && !r) || (l && !c && r))
            begin
                mdl_steer = STEER_STRAIGHT;
                mdl_motor = MOTOR_FWD;
            end
            else if ((r && !l) || (!l && c))
            begin
                mdl_steer = STEER_LEFT;
                mdl_motor = MOTOR_FWD;
            end
            else if (!r && l)
            begin
                mdl_steer = STEER_RIGHT;
                mdl_motor = MOTOR_FWD;
            end
            else
            begin
                mdl_steer = STEER_STRAIGHT;
                mdl_motor = MOTOR_REV;
            end
            if ((mdl_motor == MOTOR_REV && mdl_prev == MOTOR_FWD) || mdl_pausing)
            begin
                mdl_pausing = 1'b1;
                mdl_motor   = MOTOR_STOP;
                mdl_steer   = STEER_STRAIGHT;
                mdl_count   = mdl_count - 8'd1;
                if (mdl_count == 8'd0)
                begin
                    mdl_pausing = 1'b0;
                    mdl_count   = cfg_plen;
                end
            end
        end
        res.motor  = mdl_motor;
        res.steer  = mdl_steer;
        res.paused = mdl_pausing;
    endtask

    function automatic logic [31:0] ascii_dist(int d);
        logic [31:0] w;
        int          v;
        v = d;
        for (int k = 0; k < 4; k++)
        begin
            w[8*k +: 8] = 8'(48 + v % 10);
            v = v / 10;
        end
        return w;
    endfunction

    function automatic logic [31:0] far_reading();
        int lo;
        lo = (cfg_near > cfg_close) ? int'(cfg_near) : int'(cfg_close);
        if ($urandom_range(0, 7) == 0)
            return ascii_dist(lo);
        return ascii_dist($urandom_range(lo, 9999));
    endfunction

    function automatic logic [31:0] near_reading();
        if (cfg_near <= cfg_close)
            return far_reading();
        case ($urandom_range(0, 9))
            0: return ascii_dist(cfg_close);
            1: return ascii_dist(cfg_near - 1);
            default: return ascii_dist($urandom_range(cfg_close, cfg_near - 1));
        endcase
    endfunction

    function automatic logic [31:0] close_reading();
        logic [31:0] w;
        if (cfg_close > 0 && $urandom_range(0, 4) != 0)
        begin
            if ($urandom_range(0, 3) == 0)
                return ascii_dist(cfg_close - 1);
            return ascii_dist($urandom_range(0, cfg_close - 1));
        end
        // leading byte far below '0' keeps the distance negative
        w = $urandom();
        w[31:24] = 8'($urandom_range(0, 7));
        return w;
    endfunction

    function automatic logic [31:0] any_reading();
        logic [31:0] w;
        int          pos;
        case ($urandom_range(0, 9))
            0: return $urandom();
            1:
            begin
                w = far_reading();
                pos = $urandom_range(0, 3);
                w[8*pos +: 8] = 8'($urandom());
                return w;
            end
            2: return close_reading();
            3, 4, 5: return near_reading();
            default: return far_reading();
        endcase
    endfunction

    // mostly well-formed drive scenes: all-near frames after forward ones start pauses
    function automatic logic [95:0] random_frame();
        logic [31:0] rd [3];
        int          pick;
        pick = $urandom_range(0, 99);
        for (int k = 0; k < 3; k++)
        begin
            if (pick < 30)
                rd[k] = any_reading();
            else if (pick < 55)
                rd[k] = near_reading();
            else if (pick < 90)
                rd[k] = $urandom_range(0, 1) ? far_reading() : near_reading();
            else
                rd[k] = ($urandom_range(0, 2) == 0) ? close_reading() : far_reading();
        end
        return {rd[2], rd[1], rd[0]};
    endfunction

    task automatic pace();
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 24);
        end
        burst_left--;
    endtask

    task automatic send_frame(input logic [95:0] frame, input bit typed, input drive_t typed_res);
        drive_t res;
        pace();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= frame;
        do @(posedge clk); while (!s_axis_tready);
        compute_drive(frame, res);
        pending_drive.push_back(typed ? typed_res : res);
        frames_sent++;
    endtask

    task automatic run_random(input int count);
        drive_t none;
        none = '0;
        for (int i = 0; i < count; i++)
            send_frame(random_frame(), 1'b0, none);
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
    endtask

    task automatic drain();
        while (pending_drive.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_CLOSE_THR: cfg_close = value[THR_W-1:0];
            REG_NEAR_THR:  cfg_near  = value[THR_W-1:0];
            REG_PAUSE_LEN:
            begin
                cfg_plen = value[PLEN_W-1:0];
                if (!mdl_pausing)
                    mdl_count = cfg_plen;
            end
            default: ;  // unmapped address, write dropped
        endcase
    endtask

    task automatic reg_check(input logic [1:0] idx, input logic [31:0] want, input string name);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, prdata);
            mismatches++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_regs();
        reg_check(REG_CLOSE_THR, 32'(cfg_close), "close_threshold");
        reg_check(REG_NEAR_THR,  32'(cfg_near),  "near_threshold");
        reg_check(REG_PAUSE_LEN, 32'(cfg_plen),  "pause_length");
    endtask

    // receiver stall pattern: m_axis_tready is always high, random, sparse or toggling, by a randomly re-picked mode
    always @(posedge clk)
    begin
        ready_tick <= ready_tick + 16'd1;
        if (ready_tick % 48 == 0)
            ready_mode <= 2'($urandom_range(0, 3));
        case (ready_mode)
            2'd0: m_axis_tready <= 1'b1;
            2'd1: m_axis_tready <= 1'($urandom_range(0, 1));
            2'd2: m_axis_tready <= (ready_tick[1:0] == 2'd0);
            default: m_axis_tready <= ready_tick[4];
        endcase
    end

    always @(posedge clk)
    begin
        drive_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_drive.size() == 0)
            begin
                $error("unexpected result transfer: tdata %h", m_axis_tdata);
                mismatches++;
            end
            else
            begin
                want = pending_drive.pop_front();
                results_seen++;
                if (m_axis_tdata[1:0] !== want.motor)
                begin
                    $error("motor_cmd: expected %0d, got %0d", want.motor, m_axis_tdata[1:0]);
                    mismatches++;
                end
                if (m_axis_tdata[3:2] !== want.steer)
                begin
                    $error("steer_cmd: expected %0d, got %0d", want.steer, m_axis_tdata[3:2]);
                    mismatches++;
                end
                if (m_axis_tdata[4] !== want.paused)
                begin
                    $error("paused: expected %0d, got %0d", want.paused, m_axis_tdata[4]);
                    mismatches++;
                end
                if (want.paused)
                    paused_seen++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("sonar_obstacle_steering_tb: errors");
            $finish;
        end
    end

    initial
    begin
        drive_t row_res;
        mdl_motor   = MOTOR_STOP;
        mdl_steer   = STEER_STRAIGHT;
        mdl_prev    = MOTOR_STOP;
        mdl_pausing = 1'b0;
        mdl_count   = 8'd10;
        cfg_close   = CLOSE_THR_RST;
        cfg_near    = NEAR_THR_RST;
        cfg_plen    = PAUSE_LEN_RST;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        check_regs();

        foreach (dir_rows[i])
        begin
            row_res.motor  = dir_rows[i].motor;
            row_res.steer  = dir_rows[i].steer;
            row_res.paused = dir_rows[i].paused;
            send_frame({dir_rows[i].right, dir_rows[i].center, dir_rows[i].left},
                       dir_rows[i].typed, row_res);
        end
        run_random(120);

        for (int p = 0; p < 7; p++)
        begin
            drain();
            if (p == 1)
            begin
                reg_write(REG_UNUSED, 32'h0000_0005);
                check_regs();
            end
            reg_write(REG_CLOSE_THR, 32'(ph_close[p]));
            reg_write(REG_NEAR_THR,  32'(ph_near[p]));
            reg_write(REG_PAUSE_LEN, 32'(ph_plen[p]));
            check_regs();
            settings_run++;
            run_random(ph_items[p]);
        end
        drain();

        $display("covered %0d frames under %0d threshold settings; %0d results checked",
                 frames_sent, settings_run, results_seen);
        $display("%0d of those results fell inside a direction-change pause", paused_seen);
        if (mismatches == 0 && pending_drive.size() == 0)
            $display("sonar_obstacle_steering_tb: clean");
        else
            $display("sonar_obstacle_steering_tb: errors");
        $finish;
    end

endmodule
